// ===== rtl/bs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bs_pkg : shared constants and types of the bubble sorter
// Buffer sizing and the command/status structs that join the controller and
// the datapath.
// ----------------------------------------------------------------------------
package bs_pkg;

    // buffer capacity and derived widths
    localparam int DEPTH   = 16;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int VALUE_W = 32;

    // controller -> datapath commands
    typedef struct packed {
        logic load_in;     // accepted request: store or drop
        logic init_sort;   // set pass end index from count
        logic start_pass;  // read entry 0
        logic load_carry;  // take entry 0 as running maximum, read entry k
        logic run_step;    // compare, write lower, read next
        logic end_pass;    // write running maximum at pass end
        logic init_emit;   // emit index to zero
        logic emit_read;   // read entry to emit
        logic emit_load;   // load output register
    } dp_cmd_t;

    // datapath -> controller status
    typedef struct packed {
        logic n_ge2;       // set will hold at least two entries
        logic k_last;      // compare index at pass end
        logic end_one;     // final pass in progress
        logic emit_last;   // emit index on final entry
        logic out_free;    // output register empty or being taken
    } dp_status_t;

endpackage
`default_nettype wire

// ===== rtl/bs_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bs_if : stream interfaces of the bubble sorter
// Valid/ready channels for input elements and sorted results.
// ----------------------------------------------------------------------------
interface bs_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;
    logic               last_in;

    modport source (output valid, output value, output last_in, input ready);
    modport sink   (input valid, input value, input last_in, output ready);
endinterface

interface bs_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] sorted_value;
    logic               last_out;
    logic               overflow;

    modport source (output valid, output sorted_value, output last_out,
                    output overflow, input ready);
    modport sink   (input valid, input sorted_value, input last_out,
                    input overflow, output ready);
endinterface
`default_nettype wire

// ===== rtl/bs_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bs_datapath : element buffer, compare-swap unit and output register
// Single-write, single-read buffer with registered read data. A bubble pass
// keeps the running maximum in a carry register and writes back the lower.
// ----------------------------------------------------------------------------
module bs_datapath (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire bs_pkg::dp_cmd_t        cmd,
    output bs_pkg::dp_status_t          status,
    input  wire logic signed [31:0]     value,
    input  wire logic                   out_ready,
    output logic                        out_valid,
    output logic signed [31:0]          sorted_value,
    output logic                        last_out,
    output logic                        overflow
);
    import bs_pkg::*;

    // buffer
    logic signed [VALUE_W-1:0] mem [DEPTH];
    logic signed [VALUE_W-1:0] rdata_reg;

    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             drop_reg, drop_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic [IDX_W-1:0] end_reg, end_next;
    logic [IDX_W-1:0] emit_reg, emit_next;
    logic signed [VALUE_W-1:0] carry_reg, carry_next;

    logic                      out_valid_reg, out_valid_next;
    logic signed [VALUE_W-1:0] out_value_reg;
    logic                      out_last_reg;
    logic                      out_ovf_reg;

    logic                      full;
    logic [CNT_W-1:0]          n_after;
    logic                      wr_en;
    logic [IDX_W-1:0]          wr_addr;
    logic signed [VALUE_W-1:0] wr_data;
    logic [IDX_W-1:0]          rd_addr;
    logic                      keep_carry;
    logic                      emit_last;

    assign full       = (fill_reg == CNT_W'(DEPTH));
    assign n_after    = full ? fill_reg : fill_reg + CNT_W'(1);
    assign keep_carry = (carry_reg > rdata_reg);
    assign emit_last  = ({1'b0, emit_reg} == fill_reg - CNT_W'(1));

    // status
    always_comb
    begin
        status.n_ge2     = (n_after >= CNT_W'(2));
        status.k_last    = (k_reg == end_reg);
        status.end_one   = (end_reg == IDX_W'(1));
        status.emit_last = emit_last;
        status.out_free  = !out_valid_reg || out_ready;
    end

    // buffer port selection
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = fill_reg[IDX_W-1:0];
        wr_data = value;
        rd_addr = '0;
        if (cmd.load_in && !full)
        begin
            wr_en = 1'b1;
        end
        if (cmd.run_step)
        begin
            wr_en   = 1'b1;
            wr_addr = k_reg - IDX_W'(1);
            wr_data = keep_carry ? rdata_reg : carry_reg;
            rd_addr = k_reg + IDX_W'(1);
        end
        if (cmd.end_pass)
        begin
            wr_en   = 1'b1;
            wr_addr = end_reg;
            wr_data = carry_reg;
        end
        if (cmd.start_pass)
        begin
            rd_addr = '0;
        end
        if (cmd.load_carry)
        begin
            rd_addr = k_reg;
        end
        if (cmd.emit_read)
        begin
            rd_addr = emit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    // counters, carry and output valid
    always_comb
    begin
        fill_next      = fill_reg;
        drop_next      = drop_reg;
        k_next         = k_reg;
        end_next       = end_reg;
        emit_next      = emit_reg;
        carry_next     = carry_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (cmd.load_in)
        begin
            fill_next = n_after;
            if (full)
            begin
                drop_next = 1'b1;
            end
        end
        if (cmd.init_sort)
        begin
            end_next = IDX_W'(n_after - CNT_W'(1));
        end
        if (cmd.start_pass)
        begin
            k_next = IDX_W'(1);
        end
        if (cmd.load_carry)
        begin
            carry_next = rdata_reg;
        end
        if (cmd.run_step)
        begin
            k_next = k_reg + IDX_W'(1);
            if (!keep_carry)
            begin
                carry_next = rdata_reg;
            end
        end
        if (cmd.end_pass)
        begin
            end_next = end_reg - IDX_W'(1);
        end
        if (cmd.init_emit)
        begin
            emit_next = '0;
        end
        if (cmd.emit_load)
        begin
            out_valid_next = 1'b1;
            if (emit_last)
            begin
                fill_next = '0;
                drop_next = 1'b0;
            end
            else
            begin
                emit_next = emit_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            drop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            k_reg         <= '0;
            end_reg       <= '0;
            emit_reg      <= '0;
        end
        else
        begin
            fill_reg      <= fill_next;
            drop_reg      <= drop_next;
            out_valid_reg <= out_valid_next;
            k_reg         <= k_next;
            end_reg       <= end_next;
            emit_reg      <= emit_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        carry_reg <= carry_next;
        if (cmd.emit_load)
        begin
            out_value_reg <= rdata_reg;
            out_last_reg  <= emit_last;
            out_ovf_reg   <= drop_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign sorted_value = out_value_reg;
    assign last_out     = out_last_reg;
    assign overflow     = out_ovf_reg;

endmodule
`default_nettype wire

// ===== rtl/bs_controller.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bs_controller : sequencing state machine of the bubble sorter
// Steps through load, bubble passes and emission, issuing datapath commands.
// ----------------------------------------------------------------------------
module bs_controller (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic                in_last,
    output logic                     in_ready,
    input  wire bs_pkg::dp_status_t  status,
    output bs_pkg::dp_cmd_t          cmd
);
    import bs_pkg::*;

    typedef enum logic [2:0] {
        S_LOAD,
        S_PASS_START,
        S_PASS_LOAD0,
        S_PASS_RUN,
        S_PASS_END,
        S_EMIT_RD,
        S_EMIT_WR
    } state_t;

    state_t state_reg, state_next;
    logic   in_fire;

    assign in_ready = (state_reg == S_LOAD);
    assign in_fire  = in_valid && in_ready;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_LOAD:
            begin
                if (in_fire)
                begin
                    cmd.load_in = 1'b1;
                    if (in_last)
                    begin
                        if (status.n_ge2)
                        begin
                            cmd.init_sort = 1'b1;
                            state_next    = S_PASS_START;
                        end
                        else
                        begin
                            cmd.init_emit = 1'b1;
                            state_next    = S_EMIT_RD;
                        end
                    end
                end
            end
            S_PASS_START:
            begin
                cmd.start_pass = 1'b1;
                state_next     = S_PASS_LOAD0;
            end
            S_PASS_LOAD0:
            begin
                cmd.load_carry = 1'b1;
                state_next     = S_PASS_RUN;
            end
            S_PASS_RUN:
            begin
                cmd.run_step = 1'b1;
                if (status.k_last)
                begin
                    state_next = S_PASS_END;
                end
            end
            S_PASS_END:
            begin
                cmd.end_pass = 1'b1;
                if (status.end_one)
                begin
                    cmd.init_emit = 1'b1;
                    state_next    = S_EMIT_RD;
                end
                else
                begin
                    state_next = S_PASS_START;
                end
            end
            S_EMIT_RD:
            begin
                if (status.out_free)
                begin
                    cmd.emit_read = 1'b1;
                    state_next    = S_EMIT_WR;
                end
            end
            S_EMIT_WR:
            begin
                cmd.emit_load = 1'b1;
                state_next    = status.emit_last ? S_LOAD : S_EMIT_RD;
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/bubble_sorter_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bubble_sorter_core : streaming bubble sorter
// Collects a set of signed values, sorts it ascending and streams it out.
// ----------------------------------------------------------------------------
// Elements enter one request per cycle, only while no set is being sorted or
// emitted, into a 16-entry buffer; the request with last_in closes the set
// (elements beyond capacity are dropped and every result of that set carries
// overflow). The set is then sorted in place by bubble passes, one
// compare-and-swap per cycle through the buffer's single read port. Results
// then leave in order, each read from the buffer once the output register is
// free and then loaded into it, the final one marked last_out. A new set is
// taken as soon as the final result is in the output register. Equal values
// keep their arrival order.
module bubble_sorter_core (
    input  wire logic clk,
    input  wire logic rst_n,
    bs_in_if.sink     in_stream,
    bs_out_if.source  out_stream
);
    import bs_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    bs_controller u_controller (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_stream.valid),
        .in_last  (in_stream.last_in),
        .in_ready (in_stream.ready),
        .status   (status),
        .cmd      (cmd)
    );

    bs_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .value        (in_stream.value),
        .out_ready    (out_stream.ready),
        .out_valid    (out_stream.valid),
        .sorted_value (out_stream.sorted_value),
        .last_out     (out_stream.last_out),
        .overflow     (out_stream.overflow)
    );

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb : self-checking bench for bubble_sorter_core
// Streams sets of signed values into the sorter with random gaps and sink
// stalls, predicts the sorted run of each closed set (overflow flag, final
// marker) and compares every result against the oldest prediction. Includes
// a long sink hold-off so that the sorter fills up and pushes back on input.
// ----------------------------------------------------------------------------
module tb;

    import bs_pkg::*;

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        logic                      last_in;
    } elem_req_t;

    typedef struct {
        logic signed [VALUE_W-1:0] sorted_value;
        logic                      last_out;
        logic                      overflow;
    } sorted_res_t;

    localparam int SET_TOTAL = 430;
    localparam int HOLD_LEN  = 600;
    localparam int HOLD_AT   = 40;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    bs_in_if  in_if ();
    bs_out_if out_if ();

    bubble_sorter_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_stream  (in_if),
        .out_stream (out_if)
    );

    // requests waiting to be offered, and sorted results still owed
    elem_req_t   elem_q[$];
    sorted_res_t sorted_q[$];

    // own copy of the sorter's buffer
    logic signed [VALUE_W-1:0] set_buf [DEPTH];
    int   set_fill = 0;
    logic set_dropped = 1'b0;

    int errors = 0;

    always #5 clk = ~clk;

    // known levels before the first edge
    initial
    begin
        in_if.valid     = 1'b0;
        in_if.value     = '0;
        in_if.last_in   = 1'b0;
        out_if.ready    = 1'b0;
    end

    task automatic note_mismatch(input string msg);
        $display("tb: mismatch at %0t: %s", $time, msg);
        errors++;
    endtask

    // store one accepted request; a closing request yields the sorted run
    task automatic take_element(input elem_req_t r);
        logic signed [VALUE_W-1:0] t;
        sorted_res_t res;
        if (set_fill < DEPTH)
        begin
            set_buf[set_fill] = r.value;
            set_fill++;
        end
        else
            set_dropped = 1'b1;
        if (r.last_in)
        begin
            // bubble passes, swap only when left is strictly greater
            for (int p = 0; p + 1 < set_fill; p++)
                for (int k = 0; k + 1 < set_fill - p; k++)
                    if (set_buf[k] > set_buf[k+1])
                    begin
                        t            = set_buf[k];
                        set_buf[k]   = set_buf[k+1];
                        set_buf[k+1] = t;
                    end
            for (int k = 0; k < set_fill; k++)
            begin
                res.sorted_value = set_buf[k];
                res.last_out     = (k + 1 == set_fill);
                res.overflow     = set_dropped;
                sorted_q.push_back(res);
            end
            set_fill    = 0;
            set_dropped = 1'b0;
        end
    endtask

    function automatic int draw_wait(input bit no_idle);
        if (no_idle)
            return 0;
        return $urandom_range(0, 19);
    endfunction

    function automatic logic signed [VALUE_W-1:0] draw_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh7fff_ffff;
            1:       return 32'sh8000_0000;
            2, 3, 4: return $signed($urandom_range(0, 8)) - 4;
            default: return $urandom;
        endcase
    endfunction

    task automatic push_elem(input logic signed [VALUE_W-1:0] v, input logic lst);
        elem_req_t r;
        r.value   = v;
        r.last_in = lst;
        elem_q.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // input driver
    // ------------------------------------------------------------------
    elem_req_t cur_req;
    int  in_gap = 0;
    int  in_gap_nxt;
    bit  in_fast = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_if.valid   <= 1'b0;
            in_if.value   <= '0;
            in_if.last_in <= 1'b0;
            in_gap        <= 0;
        end
        else
        begin
            in_gap_nxt = in_gap;
            if (in_if.valid && in_if.ready)
            begin
                take_element(cur_req);
                if ($urandom_range(0, 49) == 0)
                    in_fast = ~in_fast;
                in_gap_nxt = draw_wait(in_fast);
            end
            if (in_if.valid && !in_if.ready)
                ; // request held until taken
            else if (in_gap_nxt > 0)
            begin
                in_if.valid <= 1'b0;
                in_gap_nxt--;
            end
            else if (elem_q.size() > 0)
            begin
                cur_req        = elem_q.pop_front();
                in_if.valid   <= 1'b1;
                in_if.value   <= cur_req.value;
                in_if.last_in <= cur_req.last_in;
            end
            else
                in_if.valid <= 1'b0;
            in_gap <= in_gap_nxt;
        end
    end

    // ------------------------------------------------------------------
    // output monitor and sink stalls
    // ------------------------------------------------------------------
    int  out_stall = 0;
    int  out_stall_nxt;
    int  hold_left = 0;
    int  results_seen = 0;
    bit  held = 1'b0;
    bit  out_fast = 1'b0;
    sorted_res_t want;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_if.ready <= 1'b0;
            out_stall    <= 0;
            results_seen <= 0;
        end
        else
        begin
            out_stall_nxt = out_stall;
            if (out_if.valid && out_if.ready)
            begin
                if (sorted_q.size() == 0)
                    note_mismatch($sformatf("unexpected result %0d",
                                            out_if.sorted_value));
                else
                begin
                    want = sorted_q.pop_front();
                    if (out_if.sorted_value !== want.sorted_value)
                        note_mismatch($sformatf("sorted_value %0d, want %0d",
                                                out_if.sorted_value,
                                                want.sorted_value));
                    if (out_if.last_out !== want.last_out)
                        note_mismatch($sformatf("last_out %b, want %b",
                                                out_if.last_out, want.last_out));
                    if (out_if.overflow !== want.overflow)
                        note_mismatch($sformatf("overflow %b, want %b",
                                                out_if.overflow, want.overflow));
                end
                results_seen <= results_seen + 1;
                if ($urandom_range(0, 49) == 0)
                    out_fast = ~out_fast;
                out_stall_nxt = draw_wait(out_fast);
            end
            else if (out_stall_nxt > 0)
                out_stall_nxt--;
            out_if.ready <= (out_stall_nxt == 0 && hold_left == 0);
            out_stall    <= out_stall_nxt;
        end
    end

    // one long hold-off so the sorter backs up to its input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            held      <= 1'b0;
        end
        else if (!held && results_seen == HOLD_AT)
        begin
            held      <= 1'b1;
            hold_left <= HOLD_LEN;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // ------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin
        int set_len;
        int sz;
        int issued;

        // a single element set at the maximum value
        push_elem(32'sh7fff_ffff, 1'b1);
        // two elements arriving in descending order
        push_elem(32'sh7fff_ffff, 1'b0);
        push_elem(32'sh8000_0000, 1'b1);
        // equal values and signs mixed
        push_elem(5, 1'b0);
        push_elem(-1, 1'b0);
        push_elem(5, 1'b0);
        push_elem(32'sh8000_0000, 1'b0);
        push_elem(-1, 1'b1);
        // full buffer, then the closing request is dropped too
        for (int k = 0; k < DEPTH + 1; k++)
            push_elem(32'sh7fff_fff0 - k * 32'sh0fff_ffff, k == DEPTH);
        issued = elem_q.size();

        // random sets: mostly short, some longer up to full, a few overflowing
        while (issued < SET_TOTAL)
        begin
            sz = $urandom_range(0, 19);
            if (sz < 12)
                set_len = $urandom_range(1, 6);
            else if (sz < 17)
                set_len = $urandom_range(7, DEPTH);
            else
                set_len = $urandom_range(DEPTH + 1, DEPTH + 4);
            for (int k = 0; k < set_len; k++)
                push_elem(draw_value(), k == set_len - 1);
            issued += set_len;
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (elem_q.size() != 0 || in_if.valid)
            @(posedge clk);
        while (sorted_q.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);

        if (sorted_q.size() != 0)
            note_mismatch($sformatf("%0d results never arrived", sorted_q.size()));

        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    // hard stop on a hung run
    initial
    begin
        #5_000_000;
        $display("tb: errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/bs_pkg.sv
rtl/bs_if.sv
rtl/bs_datapath.sv
rtl/bs_controller.sv
rtl/bubble_sorter_core.sv
dv/tb.sv
